/* src/lifo_pkg.sv */
// Shared types and constants for the LIFO stack with repeat count.
`timescale 1ns / 1ps

package lifo_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 2;
  localparam int REPEAT_W        = 5;

  localparam logic signed [DATA_W-1:0] POP_EMPTY_VALUE = '1;  // -1

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_COUNT = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_CNT_V,
    S_CNT_CMP,
    S_DONE
  } state_t;

endpackage

/* src/lifo_stack_with_repeat_count.sv */
// Top level: bounded LIFO stack of signed words with a repeated-entry count.
`timescale 1ns / 1ps

// Channel   Ports                                              Direction
// -------   -------------------------------------------------  ---------
// input     in_valid, in_stall, in_op, in_push_value            sink
// result    out_valid, out_stall, out_popped_value,             source
//           out_status, out_repeat_count
//
// Sequencing: push and clear finish from idle; pop waits on one entry RAM read. Count
//   visits entries k = n-1..1 and for each reads the entry, then compares it with
//   deeper entries one at a time until a match or the bottom; the single RAM read
//   port and the one comparator set this pace.
// Reset: stack empty; entry RAM contents are left as they are (no clear pass).
// Stalls: the result register holds a finished transaction while out_stall is
//   high; a new transaction is still taken and parks in a holding register.

module lifo_stack_with_repeat_count
  import lifo_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OP_W-1:0]            in_op,
  input  logic signed [DATA_W-1:0]   in_push_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DATA_W-1:0]   out_popped_value,
  output logic [STATUS_W-1:0]        out_status,
  output logic [REPEAT_W-1:0]        out_repeat_count
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int OW = $clog2(STACK_DEPTH + 1);  // occupancy holds 0..STACK_DEPTH

  // Control state
  state_t               state_r, state_nxt;
  logic [OW-1:0]        occ_r, occ_nxt;
  logic [AW-1:0]        k_r, k_nxt;      // entry being checked in count
  logic [AW-1:0]        j_r, j_nxt;      // deeper entry being compared
  logic signed [DATA_W-1:0] v_r, v_nxt;  // value of entry k
  logic [OW-1:0]        total_r, total_nxt;

  // Holding register for a result that cannot enter the output register yet
  logic signed [DATA_W-1:0] res_popped_r;
  status_t                  res_status_r;
  logic [REPEAT_W-1:0]      res_reps_r;

  // Output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_popped_r;
  status_t                  out_status_r;
  logic [REPEAT_W-1:0]      out_reps_r;

  // RAM interface
  logic                     we;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  // Sequencer decisions
  logic                     accept;
  logic                     slot_free;
  logic                     fin;
  logic signed [DATA_W-1:0] fin_popped;
  status_t                  fin_status;
  logic [REPEAT_W-1:0]      fin_reps;
  logic                     go_pop, go_cnt, go_next_entry;
  logic                     match;
  logic [OW-1:0]            occ_dec;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign occ_dec   = occ_r - OW'(1);
  assign match     = (rd_data == v_r);

  lifo_ram #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (wr_addr),
    .wr_data (in_push_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Datapath and decisions for the current cycle
  always_comb begin
    occ_nxt       = occ_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    v_nxt         = v_r;
    total_nxt     = total_r;
    we            = 1'b0;
    wr_addr       = occ_r[AW-1:0];
    rd_addr       = k_r;
    fin           = 1'b0;
    fin_popped    = '0;
    fin_status    = ST_OK;
    fin_reps      = '0;
    go_pop        = 1'b0;
    go_cnt        = 1'b0;
    go_next_entry = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_op))
            OP_PUSH: begin
              fin = 1'b1;
              if (occ_r >= OW'(STACK_DEPTH)) begin
                fin_status = ST_FULL;
              end else begin
                we      = 1'b1;
                occ_nxt = occ_r + OW'(1);
              end
            end
            OP_POP: begin
              if (occ_r == '0) begin
                fin        = 1'b1;
                fin_popped = POP_EMPTY_VALUE;
                fin_status = ST_EMPTY;
              end else begin
                occ_nxt = occ_dec;
                rd_addr = occ_dec[AW-1:0];
                go_pop  = 1'b1;
              end
            end
            OP_CLEAR: begin
              fin     = 1'b1;
              occ_nxt = '0;
            end
            OP_COUNT: begin
              if (occ_r < OW'(2)) begin
                fin = 1'b1;   // fewer than two entries: nothing to repeat
              end else begin
                k_nxt     = occ_dec[AW-1:0];
                rd_addr   = occ_dec[AW-1:0];
                total_nxt = '0;
                go_cnt    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP_RD: begin
        fin        = 1'b1;
        fin_popped = rd_data;
      end
      S_CNT_V: begin
        v_nxt   = rd_data;
        j_nxt   = k_r - AW'(1);
        rd_addr = k_r - AW'(1);
      end
      S_CNT_CMP: begin
        if (match || j_r == '0) begin
          // entry k resolved; add one if a deeper copy was found
          total_nxt = total_r + OW'(match);
          if (k_r == AW'(1)) begin
            fin      = 1'b1;
            fin_reps = REPEAT_W'(total_nxt);
          end else begin
            k_nxt         = k_r - AW'(1);
            rd_addr       = k_r - AW'(1);
            go_next_entry = 1'b1;
          end
        end else begin
          j_nxt   = j_r - AW'(1);
          rd_addr = j_r - AW'(1);
        end
      end
      S_DONE: begin
        fin        = 1'b1;
        fin_popped = res_popped_r;
        fin_status = res_status_r;
        fin_reps   = res_reps_r;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (fin) begin
      state_nxt = slot_free ? S_IDLE : S_DONE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (go_pop) begin
            state_nxt = S_POP_RD;
          end else if (go_cnt) begin
            state_nxt = S_CNT_V;
          end
        end
        S_CNT_V:   state_nxt = S_CNT_CMP;
        S_CNT_CMP: begin
          if (go_next_entry) begin
            state_nxt = S_CNT_V;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= (fin && slot_free) || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    v_r     <= v_nxt;
    total_r <= total_nxt;
    if (fin && slot_free) begin
      out_popped_r <= fin_popped;
      out_status_r <= fin_status;
      out_reps_r   <= fin_reps;
    end
    if (fin && !slot_free) begin
      res_popped_r <= fin_popped;
      res_status_r <= fin_status;
      res_reps_r   <= fin_reps;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_status       = out_status_r;
  assign out_repeat_count = out_reps_r;

endmodule

/* src/lifo_ram.sv */
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module lifo_ram
  import lifo_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
